@@ hdl/decision_tree_packet_classifier_unit_defines.svh @@
// assertion macros shared by the classifier checker
`ifndef DECISION_TREE_PACKET_CLASSIFIER_UNIT_DEFINES_SVH
`define DECISION_TREE_PACKET_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define DTPC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masked
`define DTPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/dtpc_pkg.sv @@
// ---------------------------------------------------------------------------
// dtpc_pkg
// Shared types and constants of the decision-tree packet classifier.
// ---------------------------------------------------------------------------
package dtpc_pkg;

  localparam int IDX_W       = 12;
  localparam int WORD_W      = 64;
  localparam int DIM_W       = 3;
  localparam int NUM_KEYS    = 6;
  localparam int DEPTH_OUT_W = 6;
  localparam int STATUS_W    = 2;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [DIM_W-1:0]       dim_t;
  typedef logic [DEPTH_OUT_W-1:0] depth_out_t;

  // command codes of an input word
  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_HIT       = 2'd0,
    ST_WRITTEN   = 2'd1,
    ST_DEPTH_ERR = 2'd2
  } status_t;

  // one tree node as stored in the node memory
  typedef struct packed {
    dim_t  dim;
    word_t thr;
    idx_t  left;
    idx_t  right;
  } node_t;

  // controller to datapath commands
  typedef struct packed {
    logic start_walk;  // latch keys, read root
    logic start_write; // write node, stage write result
    logic step;        // move to the chosen child
    logic cap_leaf;    // stage leaf result
    logic cap_err;     // stage depth-limit result
    logic out_load;    // move staged result to output register
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic leaf;   // current node is a leaf or out of the table
    logic at_max; // depth limit reached
  } dp_stat_t;

endpackage

@@ hdl/decision_tree_packet_classifier_unit.sv @@
// A node write stages its result, then moves it to the output register. A
// lookup reads the root, then reads one node and compares one key per tree
// level until it reaches a leaf or the depth limit, then stages its result.
// One word at a time: the next is accepted once the result moves to the
// output register, which waits while a stalled result is held. Sync reset
// clears control and the root register (to 0); node memory is not cleared.
// ---------------------------------------------------------------------------
// decision_tree_packet_classifier_unit
// Binary decision-tree packet classifier: node writes and tree lookups.
// ---------------------------------------------------------------------------
module decision_tree_packet_classifier_unit #(
  parameter int NODE_COUNT = 4096,
  parameter int DIMENSIONS = 6,
  parameter int MAX_DEPTH  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  dtpc_pkg::idx_t       cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  dtpc_pkg::idx_t       node_index,
  input  dtpc_pkg::dim_t       split_dim,
  input  dtpc_pkg::word_t      threshold,
  input  dtpc_pkg::idx_t       left_child,
  input  dtpc_pkg::idx_t       right_child,
  input  dtpc_pkg::word_t      key_dim0,
  input  dtpc_pkg::word_t      key_dim1,
  input  dtpc_pkg::word_t      key_dim2,
  input  dtpc_pkg::word_t      key_dim3,
  input  dtpc_pkg::word_t      key_dim4,
  input  dtpc_pkg::word_t      key_dim5,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output dtpc_pkg::word_t      rule_id,
  output dtpc_pkg::idx_t       leaf_index,
  output dtpc_pkg::depth_out_t walk_depth
);
  import dtpc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  word_t    keys [NUM_KEYS];
  status_t  out_status;

  // key ports gathered into one array
  assign keys[0] = key_dim0;
  assign keys[1] = key_dim1;
  assign keys[2] = key_dim2;
  assign keys[3] = key_dim3;
  assign keys[4] = key_dim4;
  assign keys[5] = key_dim5;

  assign status = out_status;

  dtpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dtpc_datapath #(
    .NODE_COUNT(NODE_COUNT),
    .DIMENSIONS(DIMENSIONS),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .node_index (node_index),
    .split_dim  (split_dim),
    .threshold  (threshold),
    .left_child (left_child),
    .right_child(right_child),
    .key_in     (keys),
    .out_status (out_status),
    .out_rule   (rule_id),
    .out_leaf   (leaf_index),
    .out_depth  (walk_depth)
  );

endmodule

@@ hdl/dtpc_ram.sv @@
// ---------------------------------------------------------------------------
// dtpc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module dtpc_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/dtpc_datapath.sv @@
// ---------------------------------------------------------------------------
// dtpc_datapath
// Node memory, walk registers, key select and compare, result registers.
// ---------------------------------------------------------------------------
module dtpc_datapath #(
  parameter int NODE_COUNT = 4096,
  parameter int DIMENSIONS = 6,
  parameter int MAX_DEPTH  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dtpc_pkg::dp_cmd_t    cmd,
  output dtpc_pkg::dp_stat_t   stat,
  input  logic                 cfg_wr_en,
  input  dtpc_pkg::idx_t       cfg_wr_data,
  input  dtpc_pkg::idx_t       node_index,
  input  dtpc_pkg::dim_t       split_dim,
  input  dtpc_pkg::word_t      threshold,
  input  dtpc_pkg::idx_t       left_child,
  input  dtpc_pkg::idx_t       right_child,
  input  dtpc_pkg::word_t      key_in [dtpc_pkg::NUM_KEYS],
  output dtpc_pkg::status_t    out_status,
  output dtpc_pkg::word_t      out_rule,
  output dtpc_pkg::idx_t       out_leaf,
  output dtpc_pkg::depth_out_t out_depth
);
  import dtpc_pkg::*;

  localparam int ADDR_W  = $clog2(NODE_COUNT);
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int NODE_W  = $bits(node_t);
  localparam logic [DEPTH_OUT_W:0] SAT = {1'b0, {DEPTH_OUT_W{1'b1}}};

  idx_t              root_node;
  idx_t              node_q;
  logic              oob_q;
  logic [DEPTH_W-1:0] depth_q;
  word_t             key_q [DIMENSIONS];

  status_t    pend_status;
  word_t      pend_rule;
  idx_t       pend_leaf;
  depth_out_t pend_depth;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic              ram_re;
  logic [NODE_W-1:0] ram_rdata;
  node_t             wr_node;
  node_t             rd_node;

  word_t key_sel;
  idx_t  next_node;
  idx_t  rd_start;

  function automatic logic idx_ok(idx_t i);
    return 32'(i) < NODE_COUNT;
  endfunction

  function automatic depth_out_t sat_depth(logic [DEPTH_W-1:0] d);
    logic [DEPTH_OUT_W:0] e;
    e = (DEPTH_OUT_W + 1)'(d);
    return (e > SAT) ? SAT[DEPTH_OUT_W-1:0] : e[DEPTH_OUT_W-1:0];
  endfunction

  // root register
  always_ff @(posedge clk) begin
    if (rst) begin
      root_node <= '0;
    end else if (cfg_wr_en) begin
      root_node <= cfg_wr_data;
    end
  end

  // node memory
  assign wr_node   = '{dim: split_dim, thr: threshold, left: left_child, right: right_child};
  assign ram_we    = cmd.start_write & idx_ok(node_index);
  assign ram_waddr = ADDR_W'(node_index);
  assign ram_re    = cmd.start_walk | cmd.step;
  assign rd_start  = cmd.start_walk ? root_node : next_node;
  assign ram_raddr = ADDR_W'(rd_start);
  assign rd_node   = node_t'(ram_rdata);

  dtpc_ram #(
    .DATA_W(NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_node),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // key select for the node's split dimension, unused dimensions read zero
  always_comb begin
    key_sel = '0;
    for (int d = 0; d < DIMENSIONS; d++) begin
      if (rd_node.dim == DIM_W'(d)) begin
        key_sel = key_q[d];
      end
    end
  end

  // branch decision
  assign next_node   = (key_sel <= rd_node.thr) ? rd_node.left : rd_node.right;
  assign stat.leaf   = oob_q | (rd_node.left == '0);
  assign stat.at_max = depth_q >= DEPTH_W'(MAX_DEPTH);

  // key capture
  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      for (int d = 0; d < DIMENSIONS; d++) begin
        key_q[d] <= key_in[d];
      end
    end
  end

  // walk position
  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      node_q  <= root_node;
      oob_q   <= ~idx_ok(root_node);
      depth_q <= '0;
    end else if (cmd.step) begin
      node_q  <= next_node;
      oob_q   <= ~idx_ok(next_node);
      depth_q <= depth_q + DEPTH_W'(1);
    end
  end

  // staged result
  always_ff @(posedge clk) begin
    if (cmd.start_write) begin
      pend_status <= ST_WRITTEN;
      pend_rule   <= '0;
      pend_leaf   <= node_index;
      pend_depth  <= '0;
    end else if (cmd.cap_leaf) begin
      pend_status <= ST_HIT;
      pend_rule   <= oob_q ? '0 : rd_node.thr;
      pend_leaf   <= node_q;
      pend_depth  <= sat_depth(depth_q);
    end else if (cmd.cap_err) begin
      pend_status <= ST_DEPTH_ERR;
      pend_rule   <= '0;
      pend_leaf   <= node_q;
      pend_depth  <= sat_depth(depth_q);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= pend_status;
      out_rule   <= pend_rule;
      out_leaf   <= pend_leaf;
      out_depth  <= pend_depth;
    end
  end

endmodule

@@ hdl/dtpc_ctrl.sv @@
// ---------------------------------------------------------------------------
// dtpc_ctrl
// Controller: accepts words, sequences the tree walk, hands off results.
// ---------------------------------------------------------------------------
module dtpc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  output logic               out_valid,
  input  logic               out_ready,
  input  dtpc_pkg::dp_stat_t stat,
  output dtpc_pkg::dp_cmd_t  cmd
);
  import dtpc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == CMD_CLASSIFY) begin
            cmd.start_walk = 1'b1;
            state_next     = S_EVAL;
          end else begin
            cmd.start_write = 1'b1;
            state_next      = S_DONE;
          end
        end
      end
      S_EVAL: begin
        priority if (stat.leaf) begin
          cmd.cap_leaf = 1'b1;
          state_next   = S_DONE;
        end else if (stat.at_max) begin
          cmd.cap_err = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/dtpc_checker.sv @@
// ---------------------------------------------------------------------------
// dtpc_checker
// Port-level checks of the classifier, bound to the top level.
// ---------------------------------------------------------------------------
`include "decision_tree_packet_classifier_unit_defines.svh"

module dtpc_checker #(
  parameter int MAX_DEPTH = 32
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           status,
  input dtpc_pkg::word_t      rule_id,
  input dtpc_pkg::idx_t       leaf_index,
  input dtpc_pkg::depth_out_t walk_depth
);
  import dtpc_pkg::*;

  // stalled result word holds
  `DTPC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(rule_id) && $stable(leaf_index) && $stable(walk_depth) && $stable(status), "stalled result word changed")

  // one word in flight: ready drops after each accept
  `DTPC_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready, "second word accepted while busy")

  // node write result carries no rule and no depth
  `DTPC_ASSERT_NOW(a_write_result, clk, rst, out_valid && (status == ST_WRITTEN), (rule_id == '0) && (walk_depth == '0), "bad node write result")

  // depth error stops exactly at the limit
  `DTPC_ASSERT_NOW(a_depth_err, clk, rst, out_valid && (status == ST_DEPTH_ERR), (rule_id == '0) && (32'(walk_depth) == ((MAX_DEPTH > 63) ? 63 : MAX_DEPTH)), "bad depth limit result")

endmodule

bind decision_tree_packet_classifier_unit dtpc_checker #(
  .MAX_DEPTH(MAX_DEPTH)
) u_dtpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .rule_id   (rule_id),
  .leaf_index(leaf_index),
  .walk_depth(walk_depth)
);

@@ verif/decision_tree_packet_classifier_unit_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decision_tree_packet_classifier_unit_checker
// Watches the config port and both word channels of the classifier. It keeps
// its own node table and root, works out the result of every accepted word
// and compares each returned result, in order, field by field.
// ---------------------------------------------------------------------------
module decision_tree_packet_classifier_unit_checker
  import dtpc_pkg::*;
#(
  parameter int NODE_COUNT = 4096,
  parameter int DIMENSIONS = 6,
  parameter int MAX_DEPTH  = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  idx_t       cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       command,
  input  idx_t       node_index,
  input  dim_t       split_dim,
  input  word_t      threshold,
  input  idx_t       left_child,
  input  idx_t       right_child,
  input  word_t      key_dim0,
  input  word_t      key_dim1,
  input  word_t      key_dim2,
  input  word_t      key_dim3,
  input  word_t      key_dim4,
  input  word_t      key_dim5,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] status,
  input  word_t      rule_id,
  input  idx_t       leaf_index,
  input  depth_out_t walk_depth,
  output int         mismatch_count,
  output int         pending_count
);

  typedef struct packed {
    status_t    status;
    word_t      rule;
    idx_t       leaf;
    depth_out_t depth;
  } lookup_result_t;

  node_t          tree_mem [NODE_COUNT];
  idx_t           root_q;
  lookup_result_t expected_results [$];
  int             mismatches;

  // walk the tree from the root for one packet key
  function automatic lookup_result_t walk_tree(input word_t k0, input word_t k1,
                                               input word_t k2, input word_t k3,
                                               input word_t k4, input word_t k5);
    word_t          keys [NUM_KEYS];
    lookup_result_t res;
    int unsigned    node;
    int unsigned    depth;
    bit             done;
    dim_t           dim;
    word_t          key;
    keys = '{k0, k1, k2, k3, k4, k5};
    node = root_q;
    depth = 0;
    done = 1'b0;
    res.status = ST_HIT;
    res.rule = '0;
    res.leaf = '0;
    res.depth = '0;
    while (!done) begin
      if (node >= NODE_COUNT) begin
        // past the table: acts as a leaf with rule 0
        res.leaf = idx_t'(node);
        done = 1'b1;
      end else if (tree_mem[node].left == '0) begin
        res.rule = tree_mem[node].thr;
        res.leaf = idx_t'(node);
        done = 1'b1;
      end else if (depth >= MAX_DEPTH) begin
        res.status = ST_DEPTH_ERR;
        res.leaf = idx_t'(node);
        done = 1'b1;
      end else begin
        // unused dimensions compare a zero key
        dim = tree_mem[node].dim;
        key = (dim < DIMENSIONS) ? keys[dim] : '0;
        node = (key <= tree_mem[node].thr) ? tree_mem[node].left : tree_mem[node].right;
        depth++;
      end
    end
    res.depth = (depth > 63) ? depth_out_t'(63) : depth_out_t'(depth);
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      root_q = '0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      // returned result against the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("mismatch at %0t: result word with nothing expected", $time);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status || rule_id !== want.rule ||
              leaf_index !== want.leaf || walk_depth !== want.depth) begin
            if (mismatches < 10) begin
              $write("mismatch at %0t: status %0d/%0d rule %h/%h ", $time,
                     want.status, status, want.rule, rule_id);
              $display("leaf %0d/%0d depth %0d/%0d (expected/actual)",
                       want.leaf, leaf_index, want.depth, walk_depth);
            end
            mismatches++;
          end
        end
      end
      // root register
      if (cfg_wr_en)
        root_q = cfg_wr_data;
      // accepted input word
      if (in_valid && in_ready) begin
        if (command == CMD_WRITE) begin
          if (node_index < NODE_COUNT) begin
            tree_mem[node_index].dim = split_dim;
            tree_mem[node_index].thr = threshold;
            tree_mem[node_index].left = left_child;
            tree_mem[node_index].right = right_child;
          end
          want.status = ST_WRITTEN;
          want.rule = '0;
          want.leaf = node_index;
          want.depth = '0;
        end else begin
          want = walk_tree(key_dim0, key_dim1, key_dim2, key_dim3, key_dim4, key_dim5);
        end
        expected_results.push_back(want);
      end
    end
    mismatch_count <= mismatches;
    pending_count <= expected_results.size();
  end

endmodule

@@ verif/decision_tree_packet_classifier_unit_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decision_tree_packet_classifier_unit_tb
// Drives node writes and packet lookups into the classifier, first a short
// directed set of trees, then randomly grown trees with random keys, under
// several sender and receiver idling mixes. The checker beside the block
// predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module decision_tree_packet_classifier_unit_tb;
  import dtpc_pkg::*;

  localparam int NODE_COUNT = 4096;
  localparam int DIMENSIONS = 6;
  localparam int MAX_DEPTH  = 32;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  idx_t       cfg_wr_data;
  logic       in_valid;
  logic       in_ready;
  logic       command;
  idx_t       node_index;
  dim_t       split_dim;
  word_t      threshold;
  idx_t       left_child;
  idx_t       right_child;
  word_t      key_dim0, key_dim1, key_dim2, key_dim3, key_dim4, key_dim5;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] status;
  word_t      rule_id;
  idx_t       leaf_index;
  depth_out_t walk_depth;

  int mismatch_count;
  int pending_count;
  int idle_pct = 0;
  int stall_pct = 0;

  // stimulus bookkeeping: only written nodes are ever reached by a walk
  bit    node_written [NODE_COUNT];
  idx_t  written_nodes [$];
  word_t thr_pool [$];
  idx_t  last_internal;
  word_t probe_keys [NUM_KEYS];

  decision_tree_packet_classifier_unit #(
    .NODE_COUNT(NODE_COUNT),
    .DIMENSIONS(DIMENSIONS),
    .MAX_DEPTH (MAX_DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .node_index (node_index),
    .split_dim  (split_dim),
    .threshold  (threshold),
    .left_child (left_child),
    .right_child(right_child),
    .key_dim0   (key_dim0),
    .key_dim1   (key_dim1),
    .key_dim2   (key_dim2),
    .key_dim3   (key_dim3),
    .key_dim4   (key_dim4),
    .key_dim5   (key_dim5),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .rule_id    (rule_id),
    .leaf_index (leaf_index),
    .walk_depth (walk_depth)
  );

  decision_tree_packet_classifier_unit_checker #(
    .NODE_COUNT(NODE_COUNT),
    .DIMENSIONS(DIMENSIONS),
    .MAX_DEPTH (MAX_DEPTH)
  ) result_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .node_index    (node_index),
    .split_dim     (split_dim),
    .threshold     (threshold),
    .left_child    (left_child),
    .right_child   (right_child),
    .key_dim0      (key_dim0),
    .key_dim1      (key_dim1),
    .key_dim2      (key_dim2),
    .key_dim3      (key_dim3),
    .key_dim4      (key_dim4),
    .key_dim5      (key_dim5),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .rule_id       (rule_id),
    .leaf_index    (leaf_index),
    .walk_depth    (walk_depth),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #20_000_000;
    $display("FAIL decision_tree_packet_classifier_unit");
    $finish;
  end

  // receiver back-pressure
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= stall_pct);

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // thresholds and keys: edges, reused thresholds, small and full-range values
  function automatic word_t pick_word();
    word_t w;
    case ($urandom_range(9))
      0: w = '0;
      1: w = '1;
      2, 3: w = (thr_pool.size() != 0) ? thr_pool[$urandom_range(thr_pool.size() - 1)]
                                       : rand_word();
      4: w = rand_word() >> $urandom_range(63);
      default: w = rand_word();
    endcase
    return w;
  endfunction

  // child among the newest nodes most of the time, so walks get long
  function automatic idx_t pick_child();
    int unsigned n;
    n = written_nodes.size();
    if ($urandom_range(4) == 0)
      return written_nodes[$urandom_range(n - 1)];
    return written_nodes[n - 1 - $urandom_range((n > 8) ? 7 : n - 1)];
  endfunction

  // offer one word and hold it until accepted
  task automatic send_word(input logic cmd, input idx_t idx, input dim_t dim,
                           input word_t thr, input idx_t left, input idx_t right,
                           input word_t keys [NUM_KEYS]);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    command <= cmd;
    node_index <= idx;
    split_dim <= dim;
    threshold <= thr;
    left_child <= left;
    right_child <= right;
    key_dim0 <= keys[0];
    key_dim1 <= keys[1];
    key_dim2 <= keys[2];
    key_dim3 <= keys[3];
    key_dim4 <= keys[4];
    key_dim5 <= keys[5];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_node(input idx_t idx, input dim_t dim, input word_t thr,
                            input idx_t left, input idx_t right);
    word_t keys [NUM_KEYS];
    foreach (keys[i]) keys[i] = rand_word();
    if (!node_written[idx]) begin
      node_written[idx] = 1'b1;
      written_nodes.push_back(idx);
    end
    if (left != '0)
      last_internal = idx;
    thr_pool.push_back(thr);
    if (thr_pool.size() > 64)
      void'(thr_pool.pop_front());
    send_word(CMD_WRITE, idx, dim, thr, left, right, keys);
  endtask

  // node fields are don't-care on a lookup, so they get random values
  task automatic lookup(input word_t keys [NUM_KEYS]);
    send_word(CMD_CLASSIFY, idx_t'($urandom), dim_t'($urandom), rand_word(),
              idx_t'($urandom), idx_t'($urandom), keys);
  endtask

  task automatic random_lookup();
    word_t keys [NUM_KEYS];
    foreach (keys[i]) keys[i] = pick_word();
    lookup(keys);
  endtask

  // write a leaf or an internal node whose children are already written
  task automatic grow_node(input bit as_leaf);
    idx_t idx;
    idx_t left;
    dim_t dim;
    // mostly fresh slots, now and then an overwrite of a live node
    if ($urandom_range(9) == 0)
      idx = written_nodes[$urandom_range(written_nodes.size() - 1)];
    else
      idx = idx_t'($urandom);
    if (as_leaf) begin
      write_node(idx, dim_t'($urandom), rand_word(), '0, idx_t'($urandom));
    end else begin
      do left = pick_child(); while (left == '0);
      dim = ($urandom_range(9) == 0) ? dim_t'($urandom_range(7, 6)) : dim_t'($urandom_range(5));
      write_node(idx, dim, pick_word(), left, pick_child());
    end
  endtask

  // root write once the block has gone quiet
  task automatic set_root(input idx_t idx);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= idx;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    command = CMD_WRITE;
    node_index = '0;
    split_dim = '0;
    threshold = '0;
    left_child = '0;
    right_child = '0;
    key_dim0 = '0;
    key_dim1 = '0;
    key_dim2 = '0;
    key_dim3 = '0;
    key_dim4 = '0;
    key_dim5 = '0;
    last_internal = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // root 0 as a leaf with the largest rule; leaf dim and right child ignored
    write_node(12'd0, dim_t'(7), '1, '0, 12'd4095);
    probe_keys = '{default: '0};
    lookup(probe_keys);

    // one split at the top index, boundary keys on dimension 0
    write_node(12'd1, dim_t'(0), 64'd1, '0, '0);
    write_node(12'd4095, dim_t'(0), '0, 12'd1, '0);
    set_root(12'd4095);
    lookup(probe_keys);
    probe_keys[0] = 64'd1;
    lookup(probe_keys);
    probe_keys[0] = '1;
    lookup(probe_keys);

    // unused dimensions compare a zero key and go left
    write_node(12'd2, dim_t'(6), '0, 12'd1, '0);
    write_node(12'd3, dim_t'(7), '0, 12'd2, 12'd4095);
    set_root(12'd3);
    probe_keys = '{default: '1};
    lookup(probe_keys);

    // self loop runs into the depth limit
    write_node(12'd5, dim_t'(5), '1, 12'd5, 12'd5);
    set_root(12'd5);
    lookup(probe_keys);

    // three-level tree over dimensions 1 to 4
    write_node(12'd6, dim_t'(1), '1, 12'd1, '0);
    write_node(12'd4094, dim_t'(4), 64'd5, 12'd4095, 12'd4095);
    write_node(12'd7, dim_t'(2), 64'h8000_0000_0000_0000, 12'd6, 12'd4094);
    write_node(12'd8, dim_t'(3), 64'h7fff_ffff_ffff_ffff, 12'd7, 12'd4094);
    set_root(12'd8);
    probe_keys = '{64'd0, '1, 64'h8000_0000_0000_0000, 64'd0, 64'd0, 64'd0};
    lookup(probe_keys);
    probe_keys = '{64'd0, 64'd0, 64'd0, '1, 64'd5, 64'd0};
    lookup(probe_keys);
    probe_keys = '{'1, 64'd0, 64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_ffff, 64'd6, '1};
    lookup(probe_keys);
    set_root(12'd0);
    lookup(probe_keys);

    // random trees under the four idling mixes
    for (int phase = 0; phase < 16; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      repeat (4) grow_node(1'b1);
      repeat (14) grow_node(1'b0);
      if ($urandom_range(3) == 0)
        set_root(written_nodes[$urandom_range(written_nodes.size() - 1)]);
      else
        set_root(last_internal);
      repeat (78) begin
        if ($urandom_range(99) < 15)
          grow_node($urandom_range(2) == 0);
        else
          random_lookup();
      end
    end

    // drain and settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("PASS decision_tree_packet_classifier_unit");
    else
      $display("FAIL decision_tree_packet_classifier_unit");
    $finish;
  end

endmodule

@@ decision_tree_packet_classifier_unit.f @@
+incdir+hdl
hdl/dtpc_pkg.sv
hdl/dtpc_ram.sv
hdl/dtpc_datapath.sv
hdl/dtpc_ctrl.sv
hdl/decision_tree_packet_classifier_unit.sv
hdl/dtpc_checker.sv
verif/decision_tree_packet_classifier_unit_checker.sv
verif/decision_tree_packet_classifier_unit_tb.sv
